// File: hdl/xcfp_pkg.sv
// ----------------------------------------------------------------------------
// xcfp_pkg
// Shared types and constants of the XOR-checked frame parser: register
// indexes, reset values of the flag registers and the result item layout.
// ----------------------------------------------------------------------------
package xcfp_pkg;

	localparam int BYTE_W     = 8;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int SUB_MAX    = 4;
	localparam int SLOT_MAX   = 2;
	localparam int IDX_OUT_W  = 5;
	localparam int CNT_OUT_W  = 6;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_HEAD_FLAG = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_END_FLAG  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SUB0_CMDS = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SUB1_CMDS = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SUB2_CMDS = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SUB3_CMDS = 3'd5;

	// Reset values of the flag registers
	localparam logic [BYTE_W-1:0] HEAD_FLAG_RST = 8'hFE;
	localparam logic [BYTE_W-1:0] END_FLAG_RST  = 8'hFF;

	// Result status codes
	localparam logic STATUS_OK        = 1'b0;
	localparam logic STATUS_CKSUM_ERR = 1'b1;

	typedef struct packed {
		logic [BYTE_W-1:0] head_flag;
		logic [BYTE_W-1:0] end_flag;
	} flags_t;

	typedef struct packed {
		logic                 status;
		logic [BYTE_W-1:0]    frame_cmd;
		logic [BYTE_W-1:0]    data_byte;
		logic [IDX_OUT_W-1:0] byte_index;
		logic [CNT_OUT_W-1:0] data_count;
		logic [SUB_MAX-1:0]   subscriber_mask;
		logic                 has_data;
		logic                 last;
	} result_t;

endpackage

// File: hdl/xcfp_byte_if.sv
// ----------------------------------------------------------------------------
// xcfp_byte_if
// Valid/ready channel that carries one received byte per item.
// ----------------------------------------------------------------------------
interface xcfp_byte_if;
	logic                      valid;
	logic                      ready;
	logic [xcfp_pkg::BYTE_W-1:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink   (input valid, input in_byte, output ready);
endinterface

// File: hdl/xcfp_result_if.sv
// ----------------------------------------------------------------------------
// xcfp_result_if
// Valid/ready channel that carries one parser result item.
// ----------------------------------------------------------------------------
interface xcfp_result_if;
	logic              valid;
	logic              ready;
	xcfp_pkg::result_t item;

	modport source (output valid, output item, input ready);
	modport sink   (input valid, input item, output ready);
endinterface

// File: hdl/xor_checked_frame_parser_unit.sv
// Result timing: an error or empty-payload result is registered in the cycle after the end byte;
//   a payload result goes through the memory read (ST_READ), ST_SEND and the output register.
// Throughput: one input byte per cycle while parsing and the output register is free; in readout
//   each payload item takes a memory read, then an output register load, and input is held off.
// Reset: control state and flags return to defaults at once; payload memory is not cleared.
// ----------------------------------------------------------------------------
// xor_checked_frame_parser_unit
// Byte-framed packet parser with XOR checksum and subscriber command match.
// ----------------------------------------------------------------------------
module xor_checked_frame_parser_unit #(
	parameter int PAYLOAD_DEPTH        = 32,
	parameter int SUBSCRIBERS          = 4,
	parameter int SLOTS_PER_SUBSCRIBER = 2
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [xcfp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [xcfp_pkg::CFG_DATA_W-1:0] cfg_wdata,
	xcfp_byte_if.sink                       rx,
	xcfp_result_if.source                   frm
);

	localparam int CNT_W  = $clog2(PAYLOAD_DEPTH + 1);
	localparam int ADDR_W = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;

	xcfp_pkg::flags_t             flags;
	logic [xcfp_pkg::SUB_MAX-1:0] match_mask;
	logic [xcfp_pkg::BYTE_W-1:0]  cmd;
	logic                         mem_we;
	logic [ADDR_W-1:0]            mem_waddr;
	logic [xcfp_pkg::BYTE_W-1:0]  mem_wdata;
	logic                         mem_re;
	logic [ADDR_W-1:0]            mem_raddr;
	logic [xcfp_pkg::BYTE_W-1:0]  mem_rdata;

	// Registers and subscriber match
	xcfp_cfg #(
		.SUBSCRIBERS          (SUBSCRIBERS),
		.SLOTS_PER_SUBSCRIBER (SLOTS_PER_SUBSCRIBER)
	) u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.cmd        (cmd),
		.flags      (flags),
		.match_mask (match_mask)
	);

	// Payload memory
	xcfp_store #(
		.DEPTH  (PAYLOAD_DEPTH),
		.ADDR_W (ADDR_W)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// Parser sequencer
	xcfp_ctrl #(
		.PAYLOAD_DEPTH (PAYLOAD_DEPTH),
		.CNT_W         (CNT_W),
		.ADDR_W        (ADDR_W)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.flags      (flags),
		.match_mask (match_mask),
		.cmd        (cmd),
		.mem_we     (mem_we),
		.mem_waddr  (mem_waddr),
		.mem_wdata  (mem_wdata),
		.mem_re     (mem_re),
		.mem_raddr  (mem_raddr),
		.mem_rdata  (mem_rdata),
		.rx         (rx),
		.frm        (frm)
	);

endmodule

// File: hdl/xcfp_cfg.sv
// ----------------------------------------------------------------------------
// xcfp_cfg
// Configuration registers (head/end flags, subscriber command slots) and
// the subscriber match on the held command byte.
// ----------------------------------------------------------------------------
module xcfp_cfg #(
	parameter int SUBSCRIBERS          = 4,
	parameter int SLOTS_PER_SUBSCRIBER = 2
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [xcfp_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [xcfp_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	input  logic [xcfp_pkg::BYTE_W-1:0]         cmd,
	output xcfp_pkg::flags_t                    flags,
	output logic [xcfp_pkg::SUB_MAX-1:0]        match_mask
);

	logic [xcfp_pkg::BYTE_W-1:0]     head_q;
	logic [xcfp_pkg::BYTE_W-1:0]     end_q;
	logic [xcfp_pkg::CFG_DATA_W-1:0] sub_q [xcfp_pkg::SUB_MAX];

	// Take register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= xcfp_pkg::HEAD_FLAG_RST;
			end_q  <= xcfp_pkg::END_FLAG_RST;
			for (int i = 0; i < xcfp_pkg::SUB_MAX; i++) begin
				sub_q[i] <= '0;
			end
		end else if (cfg_we) begin
			unique case (cfg_index)
				xcfp_pkg::REG_HEAD_FLAG: head_q   <= cfg_wdata[xcfp_pkg::BYTE_W-1:0];
				xcfp_pkg::REG_END_FLAG:  end_q    <= cfg_wdata[xcfp_pkg::BYTE_W-1:0];
				xcfp_pkg::REG_SUB0_CMDS: sub_q[0] <= cfg_wdata;
				xcfp_pkg::REG_SUB1_CMDS: sub_q[1] <= cfg_wdata;
				xcfp_pkg::REG_SUB2_CMDS: sub_q[2] <= cfg_wdata;
				xcfp_pkg::REG_SUB3_CMDS: sub_q[3] <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign flags.head_flag = head_q;
	assign flags.end_flag  = end_q;

	// Compare every enabled slot of every enabled subscriber with cmd
	always_comb begin
		match_mask = '0;
		for (int i = 0; i < xcfp_pkg::SUB_MAX; i++) begin
			for (int j = 0; j < xcfp_pkg::SLOT_MAX; j++) begin
				if (i < SUBSCRIBERS && j < SLOTS_PER_SUBSCRIBER &&
				    sub_q[i][j*xcfp_pkg::BYTE_W +: xcfp_pkg::BYTE_W] == cmd) begin
					match_mask[i] = 1'b1;
				end
			end
		end
	end

endmodule

// File: hdl/xcfp_store.sv
// ----------------------------------------------------------------------------
// xcfp_store
// Payload memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module xcfp_store #(
	parameter int DEPTH  = 32,
	parameter int ADDR_W = 5
) (
	input  logic                        clk,
	input  logic                        we,
	input  logic [ADDR_W-1:0]           waddr,
	input  logic [xcfp_pkg::BYTE_W-1:0] wdata,
	input  logic                        re,
	input  logic [ADDR_W-1:0]           raddr,
	output logic [xcfp_pkg::BYTE_W-1:0] rdata
);

	logic [xcfp_pkg::BYTE_W-1:0] mem_q [DEPTH];
	logic [xcfp_pkg::BYTE_W-1:0] rdata_q;

	// Write the stored byte, register the read data; hold data when idle
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: hdl/xcfp_ctrl.sv
// ----------------------------------------------------------------------------
// xcfp_ctrl
// Frame parser sequencer: tracks head/cmd/len/data, keeps the running XOR,
// writes payload bytes to the store and reads them back as result items.
// ----------------------------------------------------------------------------
module xcfp_ctrl #(
	parameter int PAYLOAD_DEPTH = 32,
	parameter int CNT_W         = 6,
	parameter int ADDR_W        = 5
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  xcfp_pkg::flags_t             flags,
	input  logic [xcfp_pkg::SUB_MAX-1:0] match_mask,
	output logic [xcfp_pkg::BYTE_W-1:0]  cmd,
	output logic                         mem_we,
	output logic [ADDR_W-1:0]            mem_waddr,
	output logic [xcfp_pkg::BYTE_W-1:0]  mem_wdata,
	output logic                         mem_re,
	output logic [ADDR_W-1:0]            mem_raddr,
	input  logic [xcfp_pkg::BYTE_W-1:0]  mem_rdata,
	xcfp_byte_if.sink                    rx,
	xcfp_result_if.source                frm
);

	typedef enum logic [2:0] {
		ST_WAIT,
		ST_CMD,
		ST_RECV,
		ST_READ,
		ST_SEND
	} state_t;

	state_t                       state_q;
	logic [xcfp_pkg::BYTE_W-1:0]  xor_q;
	logic [xcfp_pkg::BYTE_W-1:0]  cmd_q;
	logic [xcfp_pkg::BYTE_W-1:0]  len_q;
	logic [CNT_W-1:0]             count_q;
	logic                         expect_len_q;
	logic [xcfp_pkg::SUB_MAX-1:0] mask_q;
	logic [ADDR_W-1:0]            rd_idx_q;
	logic                         out_valid_q;
	xcfp_pkg::result_t            out_item_q;

	logic                         out_free;
	logic                         out_load;
	logic                         accept;
	logic                         is_end;
	logic                         room;
	logic                         last_rd;
	logic [xcfp_pkg::BYTE_W-1:0]  b;

	assign b        = rx.in_byte;
	assign out_free = !out_valid_q || frm.ready;
	assign rx.ready = (state_q == ST_WAIT || state_q == ST_CMD || state_q == ST_RECV)
	                  && out_free;
	assign accept   = rx.valid && rx.ready;
	assign is_end   = (b == flags.end_flag);
	assign room     = (xcfp_pkg::BYTE_W'(count_q) < len_q) &&
	                  (count_q < CNT_W'(PAYLOAD_DEPTH));
	assign last_rd  = (CNT_W'(rd_idx_q) + CNT_W'(1)) == count_q;

	// Load the output register on an error, an empty good frame or a payload byte
	assign out_load = (accept && state_q == ST_RECV && is_end &&
	                   !(xor_q == '0 && count_q != '0)) ||
	                  (state_q == ST_SEND && out_free);

	// Store a data byte while within len and depth
	assign mem_we    = accept && state_q == ST_RECV && !is_end && !expect_len_q && room;
	assign mem_waddr = count_q[ADDR_W-1:0];
	assign mem_wdata = b;
	assign mem_re    = (state_q == ST_READ);
	assign mem_raddr = rd_idx_q;

	assign cmd       = cmd_q;
	assign frm.valid = out_valid_q;
	assign frm.item  = out_item_q;

	// Parser state, frame registers and output item register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_WAIT;
			xor_q        <= '0;
			cmd_q        <= '0;
			len_q        <= '0;
			count_q      <= '0;
			expect_len_q <= 1'b0;
			mask_q       <= '0;
			rd_idx_q     <= '0;
			out_valid_q  <= 1'b0;
			out_item_q   <= '0;
		end else begin
			// Load a new item, or drop the one taken
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (frm.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_WAIT: begin
					if (accept && b == flags.head_flag) begin
						xor_q   <= flags.head_flag;
						count_q <= '0;
						state_q <= ST_CMD;
					end
				end
				ST_CMD: begin
					if (accept) begin
						cmd_q        <= b;
						xor_q        <= xor_q ^ b;
						count_q      <= '0;
						expect_len_q <= 1'b1;
						state_q      <= ST_RECV;
					end
				end
				ST_RECV: begin
					if (accept) begin
						if (is_end) begin
							expect_len_q <= 1'b0;
							if (xor_q == '0) begin
								mask_q <= match_mask;
								if (count_q == '0) begin
									// Good frame with an empty payload
									out_item_q.status          <= xcfp_pkg::STATUS_OK;
									out_item_q.frame_cmd       <= cmd_q;
									out_item_q.data_byte       <= '0;
									out_item_q.byte_index      <= '0;
									out_item_q.data_count      <= '0;
									out_item_q.subscriber_mask <= match_mask;
									out_item_q.has_data        <= 1'b0;
									out_item_q.last            <= 1'b1;
									state_q                    <= ST_WAIT;
								end else begin
									rd_idx_q <= '0;
									state_q  <= ST_READ;
								end
							end else begin
								// Checksum error
								out_item_q.status          <= xcfp_pkg::STATUS_CKSUM_ERR;
								out_item_q.frame_cmd       <= cmd_q;
								out_item_q.data_byte       <= '0;
								out_item_q.byte_index      <= '0;
								out_item_q.data_count      <= xcfp_pkg::CNT_OUT_W'(count_q);
								out_item_q.subscriber_mask <= '0;
								out_item_q.has_data        <= 1'b0;
								out_item_q.last            <= 1'b1;
								state_q                    <= ST_WAIT;
							end
						end else begin
							xor_q <= xor_q ^ b;
							if (expect_len_q) begin
								len_q        <= b;
								expect_len_q <= 1'b0;
							end else if (room) begin
								count_q <= count_q + CNT_W'(1);
							end
						end
					end
				end
				ST_READ: begin
					state_q <= ST_SEND;
				end
				ST_SEND: begin
					// Hand the read byte out, then advance or finish
					if (out_free) begin
						out_item_q.status          <= xcfp_pkg::STATUS_OK;
						out_item_q.frame_cmd       <= cmd_q;
						out_item_q.data_byte       <= mem_rdata;
						out_item_q.byte_index      <= xcfp_pkg::IDX_OUT_W'(rd_idx_q);
						out_item_q.data_count      <= xcfp_pkg::CNT_OUT_W'(count_q);
						out_item_q.subscriber_mask <= mask_q;
						out_item_q.has_data        <= 1'b1;
						out_item_q.last            <= last_rd;
						if (last_rd) begin
							state_q <= ST_WAIT;
						end else begin
							rd_idx_q <= rd_idx_q + ADDR_W'(1);
							state_q  <= ST_READ;
						end
					end
				end
				default: begin
					state_q <= ST_WAIT;
				end
			endcase
		end
	end

endmodule

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the XOR-checked frame parser. Byte items go in on
// the rx channel, while a scoreboard runs its own copy of the parser and
// queues the result items it predicts for each accepted byte. Every result
// item taken from the frm channel is compared field by field with the oldest
// prediction. Directed frames come first. Random framed traffic follows,
// mixed with noise and corrupted frames, under several register settings.
// Both channels idle at random, except in the final phase.
// ----------------------------------------------------------------------------
module tb;

	localparam int DEPTH      = 32;
	localparam int WDOG_LIMIT = 500;

	typedef enum logic [1:0] {
		PS_HUNT = 2'd0,
		PS_CMD  = 2'd1,
		PS_BODY = 2'd2
	} parse_state_t;

	// Parser mirror plus the queue of result items it has predicted
	class frame_scoreboard_t;
		logic [7:0]   head_flag;
		logic [7:0]   end_flag;
		logic [15:0]  sub_cmds [xcfp_pkg::SUB_MAX];
		parse_state_t pstate;
		logic [7:0]   run_xor;
		logic [7:0]   cmd;
		logic [7:0]   len;
		int           count;
		bit           len_next;
		logic [7:0]   payload [DEPTH];
		xcfp_pkg::result_t frame_results_due [$];
		int           errors;
		int           items_checked;
		int           frames_ok;
		int           frames_bad;

		function new();
			head_flag = xcfp_pkg::HEAD_FLAG_RST;
			end_flag  = xcfp_pkg::END_FLAG_RST;
			foreach (sub_cmds[i]) sub_cmds[i] = '0;
			pstate   = PS_HUNT;
			run_xor  = '0;
			cmd      = '0;
			len      = '0;
			count    = 0;
			len_next = 1'b0;
			errors   = 0;
			items_checked = 0;
			frames_ok  = 0;
			frames_bad = 0;
		endfunction

		function void write_reg(logic [xcfp_pkg::CFG_IDX_W-1:0] idx,
				logic [xcfp_pkg::CFG_DATA_W-1:0] val);
			unique case (idx)
				xcfp_pkg::REG_HEAD_FLAG: head_flag = val[7:0];
				xcfp_pkg::REG_END_FLAG:  end_flag  = val[7:0];
				xcfp_pkg::REG_SUB0_CMDS: sub_cmds[0] = val;
				xcfp_pkg::REG_SUB1_CMDS: sub_cmds[1] = val;
				xcfp_pkg::REG_SUB2_CMDS: sub_cmds[2] = val;
				xcfp_pkg::REG_SUB3_CMDS: sub_cmds[3] = val;
				default: ;
			endcase
		endfunction

		function logic [xcfp_pkg::SUB_MAX-1:0] cmd_match(logic [7:0] c);
			logic [xcfp_pkg::SUB_MAX-1:0] m;
			m = '0;
			for (int i = 0; i < xcfp_pkg::SUB_MAX; i++)
				for (int j = 0; j < xcfp_pkg::SLOT_MAX; j++)
					if (sub_cmds[i][8*j +: 8] == c) m[i] = 1'b1;
			return m;
		endfunction

		// Advance the parser by one accepted byte and queue what it emits
		function void note_byte(logic [7:0] b);
			xcfp_pkg::result_t r;
			logic [xcfp_pkg::SUB_MAX-1:0] m;
			unique case (pstate)
				PS_CMD: begin
					cmd      = b;
					run_xor ^= b;
					count    = 0;
					len_next = 1'b1;
					pstate   = PS_BODY;
				end
				PS_BODY: begin
					if (b == end_flag) begin
						r.frame_cmd  = cmd;
						r.data_count = count[xcfp_pkg::CNT_OUT_W-1:0];
						if (run_xor == 8'h00) begin
							m = cmd_match(cmd);
							frames_ok++;
							if (count == 0) begin
								r.status = xcfp_pkg::STATUS_OK;
								r.data_byte = '0;
								r.byte_index = '0;
								r.subscriber_mask = m;
								r.has_data = 1'b0;
								r.last = 1'b1;
								frame_results_due.push_back(r);
							end else begin
								for (int i = 0; i < count; i++) begin
									r.status = xcfp_pkg::STATUS_OK;
									r.data_byte = payload[i];
									r.byte_index = i[xcfp_pkg::IDX_OUT_W-1:0];
									r.subscriber_mask = m;
									r.has_data = 1'b1;
									r.last = (i + 1 == count);
									frame_results_due.push_back(r);
								end
							end
						end else begin
							frames_bad++;
							r.status = xcfp_pkg::STATUS_CKSUM_ERR;
							r.data_byte = '0;
							r.byte_index = '0;
							r.subscriber_mask = '0;
							r.has_data = 1'b0;
							r.last = 1'b1;
							frame_results_due.push_back(r);
						end
						len_next = 1'b0;
						pstate   = PS_HUNT;
					end else begin
						run_xor ^= b;
						if (len_next) begin
							len      = b;
							len_next = 1'b0;
						end else if (count < len && count < DEPTH) begin
							payload[count] = b;
							count++;
						end
					end
				end
				default: begin
					// unused state code behaves as hunting for head
					pstate = PS_HUNT;
					if (b == head_flag) begin
						run_xor = head_flag;
						count   = 0;
						pstate  = PS_CMD;
					end
				end
			endcase
		endfunction

		function void cmp(string name, logic [7:0] want, logic [7:0] seen);
			if (want !== seen) begin
				errors++;
				$display("%0t: %s mismatch, expected %0h actual %0h",
					$time, name, want, seen);
			end
		endfunction

		// Compare one result item with the oldest prediction
		function void check_result(xcfp_pkg::result_t got);
			xcfp_pkg::result_t want;
			if (frame_results_due.size() == 0) begin
				errors++;
				$display("%0t: unexpected result item, expected none actual %0h",
					$time, got);
				return;
			end
			want = frame_results_due.pop_front();
			items_checked++;
			cmp("status", want.status, got.status);
			cmp("frame_cmd", want.frame_cmd, got.frame_cmd);
			cmp("data_byte", want.data_byte, got.data_byte);
			cmp("byte_index", want.byte_index, got.byte_index);
			cmp("data_count", want.data_count, got.data_count);
			cmp("subscriber_mask", want.subscriber_mask, got.subscriber_mask);
			cmp("has_data", want.has_data, got.has_data);
			cmp("last", want.last, got.last);
		endfunction
	endclass

	logic                            clk = 1'b0;
	logic                            arst_n;
	logic                            cfg_we;
	logic [xcfp_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [xcfp_pkg::CFG_DATA_W-1:0] cfg_wdata;
	bit                              calm = 1'b0;
	int                              bytes_in = 0;
	int                              quiet_cycles = 0;

	frame_scoreboard_t sb = new();

	xcfp_byte_if   rx_if ();
	xcfp_result_if frm_if ();

	xor_checked_frame_parser_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.rx        (rx_if),
		.frm       (frm_if)
	);

	always #1 clk = ~clk;

	// Sample both channels on the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (rx_if.valid && rx_if.ready) begin
				sb.note_byte(rx_if.in_byte);
				bytes_in++;
			end
			if (frm_if.valid && frm_if.ready)
				sb.check_result(frm_if.item);
		end
	end

	// Watchdog on stretches with no item moving
	always @(posedge clk) begin
		if (arst_n) begin
			if ((rx_if.valid && rx_if.ready) || (frm_if.valid && frm_if.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WDOG_LIMIT) begin
				$display("%0t: watchdog expired, %0d result items still due",
					$time, sb.frame_results_due.size());
				$display("tb: errors");
				$finish;
			end
		end
	end

	// Result sink: random stall bursts unless calm
	initial begin
		frm_if.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!calm && $urandom_range(0, 5) == 0) begin
				frm_if.ready = 1'b0;
				repeat ($urandom_range(0, 11)) @(negedge clk);
			end else begin
				frm_if.ready = 1'b1;
			end
		end
	end

	// Offer one byte, with an optional idle burst first; return at a falling edge
	task automatic send_byte(input logic [7:0] b);
		if (!calm && $urandom_range(0, 7) == 0) begin
			rx_if.valid = 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
		end
		rx_if.valid = 1'b1;
		rx_if.in_byte = b;
		do @(posedge clk); while (!(rx_if.valid && rx_if.ready));
		@(negedge clk);
	endtask

	// Send head, cmd, len, n data bytes, checksum and end; corrupt flips a checksum bit
	task automatic send_framed(input logic [7:0] cmd, input int len, input int n,
			input bit corrupt);
		logic [7:0] sum;
		logic [7:0] d;
		sum = sb.head_flag;
		send_byte(sb.head_flag);
		sum ^= cmd;
		send_byte(cmd);
		sum ^= len[7:0];
		send_byte(len[7:0]);
		for (int i = 0; i < n; i++) begin
			d = 8'($urandom_range(0, 255));
			if (d == sb.end_flag) d ^= 8'h01;
			sum ^= d;
			send_byte(d);
		end
		if (corrupt) sum ^= 8'h01 << $urandom_range(0, 7);
		send_byte(sum);
		send_byte(sb.end_flag);
	endtask

	// Mostly well-formed frames; some noise and corrupted checksums
	task automatic send_random_frame();
		int kind;
		int len;
		int n;
		logic [15:0] slots;
		logic [7:0] cmd;
		kind = $urandom_range(0, 9);
		if (kind == 0) begin
			repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(0, 255)));
		end else begin
			case ($urandom_range(0, 9))
				0:       len = $urandom_range(32, 40);
				1, 2:    len = $urandom_range(9, 31);
				default: len = $urandom_range(0, 8);
			endcase
			n = ($urandom_range(0, 4) == 0) ? $urandom_range(0, len + 3) : len;
			slots = sb.sub_cmds[$urandom_range(0, xcfp_pkg::SUB_MAX - 1)];
			if ($urandom_range(0, 9) < 6)
				cmd = $urandom_range(0, 1) ? slots[15:8] : slots[7:0];
			else
				cmd = 8'($urandom_range(0, 255));
			send_framed(cmd, len, n, kind == 1);
		end
	endtask

	task automatic random_traffic(input int nbytes);
		int stop_at;
		stop_at = bytes_in + nbytes;
		while (bytes_in < stop_at) send_random_frame();
	endtask

	// Stop offering bytes and let every due result item drain
	task automatic settle();
		rx_if.valid = 1'b0;
		while (sb.frame_results_due.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_cfg(input logic [xcfp_pkg::CFG_IDX_W-1:0] idx,
			input logic [xcfp_pkg::CFG_DATA_W-1:0] val);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_wdata = val;
		sb.write_reg(idx, val);
		@(negedge clk);
	endtask

	task automatic apply_cfg(input logic [7:0] head, input logic [7:0] tail,
			input logic [15:0] s0, input logic [15:0] s1,
			input logic [15:0] s2, input logic [15:0] s3);
		write_cfg(xcfp_pkg::REG_HEAD_FLAG, {8'h00, head});
		write_cfg(xcfp_pkg::REG_END_FLAG, {8'h00, tail});
		write_cfg(xcfp_pkg::REG_SUB0_CMDS, s0);
		write_cfg(xcfp_pkg::REG_SUB1_CMDS, s1);
		write_cfg(xcfp_pkg::REG_SUB2_CMDS, s2);
		write_cfg(xcfp_pkg::REG_SUB3_CMDS, s3);
		cfg_we = 1'b0;
	endtask

	// Main sequence
	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		rx_if.valid = 1'b0;
		rx_if.in_byte = '0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed frames at reset settings (head FE, end FF, all slots zero)
		send_byte(8'h00);                            // noise before head
		send_byte(8'hFF);
		send_byte(8'hFE); send_byte(8'h00);          // empty payload, all subscribers
		send_byte(8'h00); send_byte(8'hFE); send_byte(8'hFF);
		send_byte(8'hFE); send_byte(8'h11);          // len byte equal to end
		send_byte(8'hFF);
		send_byte(8'hFE); send_byte(8'hFF);          // cmd equal to end, no subscriber
		send_byte(8'h01); send_byte(8'hAA); send_byte(8'hAA); send_byte(8'hFF);
		send_byte(8'hFE); send_byte(8'h00);          // head byte and zero as data
		send_byte(8'h02); send_byte(8'h00); send_byte(8'hFE);
		send_byte(8'h02); send_byte(8'hFF);
		send_byte(8'hFE); send_byte(8'h00);          // bad checksum
		send_byte(8'h02); send_byte(8'h01); send_byte(8'h02);
		send_byte(8'h00); send_byte(8'hFF);
		random_traffic(40);
		settle();

		// Extreme settings
		apply_cfg(8'h00, 8'hFF, 16'h0000, 16'hFFFF, 16'h00FF, 16'hFF00);
		random_traffic(75);
		settle();
		apply_cfg(8'hFF, 8'h00, 16'hFFFF, 16'h0000, 16'h8001, 16'h7FFE);
		random_traffic(75);
		settle();

		// Head and end share one value
		apply_cfg(8'h7E, 8'h7E, 16'h1234, 16'h3456, 16'h5678, 16'h1278);
		random_traffic(75);
		settle();

		// Random settings; the last phase runs without idling
		apply_cfg(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
			16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
			16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
		random_traffic(75);
		settle();
		calm = 1'b1;
		apply_cfg(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
			16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
			16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
		random_traffic(60);
		settle();
		repeat (10) @(negedge clk);

		if (sb.frame_results_due.size() != 0) begin
			sb.errors++;
			$display("%0t: %0d result items never arrived", $time,
				sb.frame_results_due.size());
		end
		$display("summary: %0d bytes parsed under 6 register settings, %0d result items compared",
			bytes_in, sb.items_checked);
		$display("summary: %0d frames with a good checksum, %0d with a bad one",
			sb.frames_ok, sb.frames_bad);
		if (sb.errors == 0) begin
			$display("tb: clean");
		end else begin
			$display("tb: errors");
		end
		$finish;
	end

endmodule

// File: filelist.f
hdl/xcfp_pkg.sv
hdl/xcfp_byte_if.sv
hdl/xcfp_result_if.sv
hdl/xcfp_cfg.sv
hdl/xcfp_store.sv
hdl/xcfp_ctrl.sv
hdl/xor_checked_frame_parser_unit.sv
sim/tb.sv
